>>> rtl/mte_pkg.sv
// mte_pkg: shared types and opcodes of the 4x4 matrix transform engine
// used by every module under rtl and by the port checker
package mte_pkg;

	localparam logic [2:0] OP_LOAD      = 3'd0;
	localparam logic [2:0] OP_TRANSFORM = 3'd1;
	localparam logic [2:0] OP_TRANSLATE = 3'd2;
	localparam logic [2:0] OP_SCALE     = 3'd3;
	localparam logic [2:0] OP_SET_TRANS = 3'd4;
	localparam logic [2:0] OP_READ      = 3'd5;

	typedef logic signed [31:0] cell_t;
	typedef cell_t [3:0] col_t;
	typedef col_t [3:0] mat_t;

	typedef struct packed {
		logic [2:0]         op;
		logic [1:0]         col_index;
		logic signed [31:0] in_x;
		logic signed [31:0] in_y;
		logic signed [31:0] in_z;
		logic signed [31:0] in_w;
	} cmd_word_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic signed [31:0] out_w;
		logic               saturated;
	} rsp_word_t;

	typedef struct packed {
		logic wr;
		logic set_ovf;
		logic clr_ovf;
	} upd_t;

endpackage

>>> rtl/mte_calc.sv
// mte_calc: sixteen multipliers, row sums, saturation and op decode
// combinational; depends on mte_pkg
module mte_calc #(
	parameter int FRAC_BITS = 16
) (
	input  mte_pkg::cmd_word_t cmd,
	input  logic               fire,
	input  mte_pkg::mat_t      mat,
	input  logic               ovf,
	output mte_pkg::mat_t      mat_next,
	output mte_pkg::rsp_word_t rsp,
	output logic               has_rsp,
	output mte_pkg::upd_t      upd
);
	import mte_pkg::*;

	localparam int SUM_W = 67;

	function automatic logic ovf_of(input logic signed [SUM_W-1:0] x);
		logic [SUM_W-32:0] top;
		top = x[SUM_W-1:31];
		return !((&top) || !(|top));
	endfunction

	function automatic cell_t clamp(input logic signed [SUM_W-1:0] x);
		cell_t res;
		if (ovf_of(x)) begin
			res = x[SUM_W-1] ? cell_t'(32'h8000_0000) : cell_t'(32'h7fff_ffff);
		end else begin
			res = cell_t'(x[31:0]);
		end
		return res;
	endfunction

	cell_t                    vec [4];
	logic signed [63:0]       prod [4][4];
	logic signed [SUM_W-1:0]  sh [4][4];
	logic signed [SUM_W-1:0]  tot [4];
	logic                     row_ovf;
	logic                     cell_ovf;
	logic                     wr;
	logic                     hit;

	always_comb begin
		vec[0] = cmd.in_x;
		vec[1] = cmd.in_y;
		vec[2] = cmd.in_z;
		vec[3] = cmd.in_w;

		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				prod[c][r] = $signed(mat[c][r]) * $signed(vec[c]);
				sh[c][r]   = SUM_W'(prod[c][r] >>> FRAC_BITS);
			end
		end

		row_ovf  = 1'b0;
		cell_ovf = 1'b0;
		for (int r = 0; r < 4; r++) begin
			tot[r] = sh[0][r] + sh[1][r] + sh[2][r]
				+ ((cmd.op == OP_TRANSLATE) ? SUM_W'($signed(mat[3][r])) : sh[3][r]);
			row_ovf = row_ovf | ovf_of(tot[r]);
		end
		for (int c = 0; c < 3; c++) begin
			for (int r = 0; r < 4; r++) begin
				cell_ovf = cell_ovf | ovf_of(sh[c][r]);
			end
		end

		mat_next = mat;
		rsp      = '0;
		has_rsp  = 1'b0;
		wr       = 1'b0;
		hit      = 1'b0;

		case (cmd.op)
			OP_LOAD: begin
				wr = 1'b1;
				for (int r = 0; r < 4; r++) begin
					mat_next[cmd.col_index][r] = vec[r];
				end
			end
			OP_TRANSFORM: begin
				has_rsp       = 1'b1;
				hit           = row_ovf;
				rsp.out_x     = clamp(tot[0]);
				rsp.out_y     = clamp(tot[1]);
				rsp.out_z     = clamp(tot[2]);
				rsp.out_w     = clamp(tot[3]);
				rsp.saturated = row_ovf;
			end
			OP_TRANSLATE: begin
				wr  = 1'b1;
				hit = row_ovf;
				for (int r = 0; r < 4; r++) begin
					mat_next[3][r] = clamp(tot[r]);
				end
			end
			OP_SCALE: begin
				wr  = 1'b1;
				hit = cell_ovf;
				for (int c = 0; c < 3; c++) begin
					for (int r = 0; r < 4; r++) begin
						mat_next[c][r] = clamp(sh[c][r]);
					end
				end
			end
			OP_SET_TRANS: begin
				wr = 1'b1;
				for (int r = 0; r < 3; r++) begin
					mat_next[3][r] = vec[r];
				end
			end
			OP_READ: begin
				has_rsp       = 1'b1;
				rsp.out_x     = mat[cmd.col_index][0];
				rsp.out_y     = mat[cmd.col_index][1];
				rsp.out_z     = mat[cmd.col_index][2];
				rsp.out_w     = mat[cmd.col_index][3];
				rsp.saturated = ovf;
			end
			default: begin
			end
		endcase

		upd.wr      = fire && wr;
		upd.set_ovf = fire && hit;
		upd.clr_ovf = fire && (cmd.op == OP_READ);
	end

endmodule

>>> rtl/mte_state.sv
// mte_state: matrix cell registers and the sticky overflow flag
// depends on mte_pkg
module mte_state #(
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  mte_pkg::upd_t upd,
	input  mte_pkg::mat_t mat_next,
	output mte_pkg::mat_t mat,
	output logic          ovf
);
	import mte_pkg::*;

	localparam cell_t ONE = cell_t'(64'(1) << FRAC_BITS);

	mat_t mat_q;
	logic ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 4; r++) begin
					mat_q[c][r] <= (c == r) ? ONE : '0;
				end
			end
			ovf_q <= 1'b0;
		end else begin
			if (upd.wr) begin
				mat_q <= mat_next;
			end
			if (upd.set_ovf) begin
				ovf_q <= 1'b1;
			end else if (upd.clr_ovf) begin
				ovf_q <= 1'b0;
			end
		end
	end

	assign mat = mat_q;
	assign ovf = ovf_q;

endmodule

>>> rtl/matrix4_transform_engine_unit.sv
// matrix4_transform_engine_unit: 4x4 Q16.16 matrix-vector transform engine
// accept to result word: input register, then result register; the matrix update of a word
// lands before the next reads it; throughput: one word per cycle unless a result is stalled
// reset: matrix to identity, overflow flag cleared, both stages empty
// depends on mte_pkg, mte_calc, mte_state
module matrix4_transform_engine_unit #(
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	input  mte_pkg::cmd_word_t cmd,
	output logic               rsp_valid,
	input  logic               rsp_ready,
	output mte_pkg::rsp_word_t rsp
);
	import mte_pkg::*;

	cmd_word_t cmd_s1;
	logic      valid_s1;
	rsp_word_t rsp_s2;
	logic      valid_s2;

	mat_t      mat;
	mat_t      mat_next;
	logic      ovf;
	rsp_word_t rsp_d;
	logic      has_rsp;
	logic      advance;
	upd_t      upd;

	assign advance   = valid_s1 && (!has_rsp || !valid_s2 || rsp_ready);
	assign cmd_ready = !valid_s1 || advance;

	mte_calc #(
		.FRAC_BITS(FRAC_BITS)
	) u_calc (
		.cmd      (cmd_s1),
		.fire     (advance),
		.mat      (mat),
		.ovf      (ovf),
		.mat_next (mat_next),
		.rsp      (rsp_d),
		.has_rsp  (has_rsp),
		.upd      (upd)
	);

	mte_state #(
		.FRAC_BITS(FRAC_BITS)
	) u_state (
		.clk      (clk),
		.arst_n   (arst_n),
		.upd      (upd),
		.mat_next (mat_next),
		.mat      (mat),
		.ovf      (ovf)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= (cmd_valid && cmd_ready) || (valid_s1 && !advance);
			valid_s2 <= (advance && has_rsp) || (valid_s2 && !rsp_ready);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_s1 <= cmd;
		end
		if (advance && has_rsp) begin
			rsp_s2 <= rsp_d;
		end
	end

	assign rsp_valid = valid_s2;
	assign rsp       = rsp_s2;

endmodule

>>> rtl/mte_checker.sv
// mte_checker: port-level checks of the transform engine, bound to the top level
// depends on mte_pkg and matrix4_transform_engine_unit
module mte_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               cmd_valid,
	input logic               cmd_ready,
	input mte_pkg::cmd_word_t cmd,
	input logic               rsp_valid,
	input logic               rsp_ready,
	input mte_pkg::rsp_word_t rsp
);
	import mte_pkg::*;

	// stalled result word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
		else $error("result word dropped or changed while stalled");

	// input backs up only behind a stalled result
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd_ready |-> rsp_valid && !rsp_ready)
		else $error("input stalled without a stalled result");

	// no result word out of idle without an accepted input word ahead of it
	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		!$past(rsp_valid) && !$past(cmd_valid && cmd_ready, 2) |-> !rsp_valid)
		else $error("result word with no accepted input word");

endmodule

bind matrix4_transform_engine_unit mte_checker u_mte_checker (.*);

>>> test/tb_matrix4_transform_engine_unit.sv
// tb_matrix4_transform_engine_unit: self-checking bench for the 4x4 matrix transform engine
// directed corner words, then random load/transform/update sequences checked against a predictor
// depends on mte_pkg and matrix4_transform_engine_unit
module tb_matrix4_transform_engine_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import mte_pkg::*;

	localparam int FRAC = 16;
	localparam logic [2:0] OP_SPARE_A = 3'd6;
	localparam logic [2:0] OP_SPARE_B = 3'd7;
	localparam logic [31:0] CELL_MAX = 32'h7fff_ffff;
	localparam logic [31:0] CELL_MIN = 32'h8000_0000;
	localparam logic [31:0] ONE_Q = 32'h0001_0000;
	localparam logic [31:0] MINUS_ONE_Q = 32'hffff_0000;
	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	typedef struct {
		bit        hold;
		cmd_word_t w;
	} backlog_entry_t;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_ready;
	cmd_word_t cmd = '0;
	logic      rsp_valid;
	logic      rsp_ready = 1'b0;
	rsp_word_t rsp;

	logic signed [31:0] mtx [4][4];
	bit                 ovf_sticky;
	rsp_word_t          expected_cols[$];
	backlog_entry_t     cmd_backlog[$];
	backlog_entry_t     backlog_head;
	rsp_word_t          want_word;

	int n_queued = 0;
	int n_total = 0;
	int n_accepted = 0;
	int n_checked = 0;
	int n_sat_words = 0;
	int n_errors = 0;
	int op_seen [8];
	int send_gap = 0;
	int recv_gap = 0;

	matrix4_transform_engine_unit #(.FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd(cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp)
	);

	always #10 clk = ~clk;

	function automatic longint fix_mul(input logic signed [31:0] a, input logic signed [31:0] b);
		longint p;
		p = longint'(a) * longint'(b);
		return p >>> FRAC;
	endfunction

	function automatic logic signed [31:0] clamp32(input longint s, inout bit sat);
		if (s > S32_MAX) begin
			sat = 1'b1;
			return CELL_MAX;
		end
		if (s < S32_MIN) begin
			sat = 1'b1;
			return CELL_MIN;
		end
		return s[31:0];
	endfunction

	function automatic void reset_matrix();
		for (int c = 0; c < 4; c++)
			for (int r = 0; r < 4; r++)
				mtx[c][r] = (c == r) ? ONE_Q : '0;
		ovf_sticky = 1'b0;
	endfunction

	function automatic void apply_command(input cmd_word_t c);
		logic signed [31:0] vec [4];
		logic signed [31:0] res [4];
		longint acc;
		bit sat;
		rsp_word_t w;
		vec[0] = c.in_x;
		vec[1] = c.in_y;
		vec[2] = c.in_z;
		vec[3] = c.in_w;
		sat = 1'b0;
		case (c.op)
			OP_LOAD: begin
				for (int r = 0; r < 4; r++)
					mtx[c.col_index][r] = vec[r];
			end
			OP_TRANSFORM: begin
				for (int r = 0; r < 4; r++) begin
					acc = 0;
					for (int k = 0; k < 4; k++)
						acc += fix_mul(mtx[k][r], vec[k]);
					res[r] = clamp32(acc, sat);
				end
				if (sat)
					ovf_sticky = 1'b1;
			end
			OP_TRANSLATE: begin
				for (int r = 0; r < 4; r++) begin
					acc = longint'(mtx[3][r]);
					for (int k = 0; k < 3; k++)
						acc += fix_mul(mtx[k][r], vec[k]);
					res[r] = clamp32(acc, sat);
				end
				for (int r = 0; r < 4; r++)
					mtx[3][r] = res[r];
				if (sat)
					ovf_sticky = 1'b1;
			end
			OP_SCALE: begin
				for (int k = 0; k < 3; k++)
					for (int r = 0; r < 4; r++)
						mtx[k][r] = clamp32(fix_mul(mtx[k][r], vec[k]), sat);
				if (sat)
					ovf_sticky = 1'b1;
			end
			OP_SET_TRANS: begin
				for (int r = 0; r < 3; r++)
					mtx[3][r] = vec[r];
			end
			OP_READ: begin
				for (int r = 0; r < 4; r++)
					res[r] = mtx[c.col_index][r];
				sat = ovf_sticky;
				ovf_sticky = 1'b0;
			end
			default: ;
		endcase
		if (c.op == OP_TRANSFORM || c.op == OP_READ) begin
			w.out_x = res[0];
			w.out_y = res[1];
			w.out_z = res[2];
			w.out_w = res[3];
			w.saturated = sat;
			expected_cols.push_back(w);
		end
	endfunction

	task automatic check_word(input rsp_word_t want, input rsp_word_t got);
		logic signed [31:0] wv [4];
		logic signed [31:0] gv [4];
		wv = '{want.out_x, want.out_y, want.out_z, want.out_w};
		gv = '{got.out_x, got.out_y, got.out_z, got.out_w};
		for (int i = 0; i < 4; i++)
			if (gv[i] !== wv[i]) begin
				$display("%0t: row %0d mismatch: expected %0d, actual %0d", $time, i, wv[i], gv[i]);
				n_errors++;
			end
		if (got.saturated !== want.saturated) begin
			$display("%0t: saturated mismatch: expected %0b, actual %0b", $time,
				want.saturated, got.saturated);
			n_errors++;
		end
	endtask

	task automatic queue_cmd(input logic [2:0] op, input logic [1:0] ci, input logic [31:0] x,
		input logic [31:0] y, input logic [31:0] z, input logic [31:0] w);
		backlog_entry_t e;
		e.hold = 1'b0;
		e.w.op = op;
		e.w.col_index = ci;
		e.w.in_x = x;
		e.w.in_y = y;
		e.w.in_z = z;
		e.w.in_w = w;
		cmd_backlog.push_back(e);
		if (op <= OP_READ)
			n_queued++;
	endtask

	task automatic queue_hold();
		backlog_entry_t e;
		e.hold = 1'b1;
		e.w = '0;
		cmd_backlog.push_back(e);
	endtask

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 6))
			0: return CELL_MAX;
			1: return CELL_MIN;
			2: return '0;
			3: return '1;
			4: return ONE_Q;
			5: return MINUS_ONE_Q;
			default: return 32'd1;
		endcase
	endfunction

	function automatic logic [31:0] val_mix();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 50)
			return int'($urandom_range(0, 1 << 20)) - (1 << 19);
		if (sel < 65)
			return int'($urandom_range(0, 1 << 17)) - (1 << 16);
		if (sel < 80)
			return $urandom;
		if (sel < 90)
			return pick_extreme();
		return int'($urandom_range(0, 1 << 25)) - (1 << 24);
	endfunction

	function automatic logic [31:0] near_one();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel < 6)
			return int'(ONE_Q) + int'($urandom_range(0, 1 << 14)) - (1 << 13);
		if (sel < 8)
			return -int'(ONE_Q) + int'($urandom_range(0, 1 << 14)) - (1 << 13);
		return val_mix();
	endfunction

	function automatic logic [1:0] any_col();
		return 2'($urandom_range(0, 3));
	endfunction

	function automatic bit idle_on();
		return (n_accepted + 150 < n_total) && (((n_accepted >> 7) % 3) != 2);
	endfunction

	task automatic build_directed();
		queue_cmd(OP_READ, 2'd0, $urandom, $urandom, $urandom, $urandom);
		queue_cmd(OP_READ, 2'd3, $urandom, $urandom, $urandom, $urandom);
		queue_cmd(OP_TRANSFORM, any_col(), CELL_MAX, CELL_MIN, '1, ONE_Q);
		queue_cmd(OP_TRANSFORM, any_col(), '0, '0, '0, '0);
		queue_cmd(OP_LOAD, 2'd0, CELL_MAX, CELL_MAX, CELL_MAX, CELL_MAX);
		queue_cmd(OP_LOAD, 2'd1, CELL_MIN, CELL_MIN, CELL_MIN, CELL_MIN);
		// positive then negative saturation on every row
		queue_cmd(OP_TRANSFORM, any_col(), CELL_MAX, '0, '0, '0);
		queue_cmd(OP_TRANSFORM, any_col(), '0, CELL_MAX, '0, '0);
		queue_cmd(OP_READ, 2'd1, $urandom, $urandom, $urandom, $urandom);
		queue_cmd(OP_READ, 2'd2, $urandom, $urandom, $urandom, $urandom);
		queue_hold();
		// truncation toward minus infinity on tiny products
		queue_cmd(OP_LOAD, 2'd0, 32'd1, '1, ONE_Q, '1);
		queue_cmd(OP_TRANSFORM, any_col(), '1, '0, '0, '0);
		queue_cmd(OP_TRANSLATE, any_col(), '0, CELL_MAX, '0, $urandom);
		queue_cmd(OP_SCALE, any_col(), CELL_MAX, CELL_MIN, MINUS_ONE_Q, $urandom);
		queue_cmd(OP_SET_TRANS, any_col(), 32'h1234_5678, CELL_MIN, CELL_MAX, $urandom);
		queue_cmd(OP_READ, 2'd3, $urandom, $urandom, $urandom, $urandom);
		queue_cmd(OP_READ, 2'd0, $urandom, $urandom, $urandom, $urandom);
		queue_cmd(OP_READ, 2'd1, $urandom, $urandom, $urandom, $urandom);
		queue_cmd(OP_SPARE_A, any_col(), $urandom, $urandom, $urandom, $urandom);
		queue_cmd(OP_SPARE_B, any_col(), $urandom, $urandom, $urandom, $urandom);
		queue_cmd(OP_LOAD, 2'd2, $urandom, $urandom, $urandom, $urandom);
		queue_cmd(OP_READ, 2'd2, $urandom, $urandom, $urandom, $urandom);
		queue_cmd(OP_TRANSFORM, any_col(), $urandom, $urandom, $urandom, $urandom);
	endtask

	task automatic build_random();
		int kind;
		while (n_queued < 1750 + 22) begin
			kind = $urandom_range(0, 99);
			if (kind < 35) begin
				for (int c = 0; c < 4; c++)
					queue_cmd(OP_LOAD, 2'(c), val_mix(), val_mix(), val_mix(), val_mix());
				repeat ($urandom_range(1, 8))
					queue_cmd(OP_TRANSFORM, any_col(), val_mix(), val_mix(), val_mix(), val_mix());
				if ($urandom_range(0, 1))
					queue_cmd(OP_READ, any_col(), $urandom, $urandom, $urandom, $urandom);
			end else if (kind < 60) begin
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(0, 2))
						0: queue_cmd(OP_TRANSLATE, any_col(), val_mix(), val_mix(), val_mix(),
							$urandom);
						1: queue_cmd(OP_SCALE, any_col(), near_one(), near_one(), near_one(),
							$urandom);
						default: queue_cmd(OP_SET_TRANS, any_col(), val_mix(), val_mix(),
							val_mix(), $urandom);
					endcase
				end
				repeat ($urandom_range(1, 4))
					queue_cmd(OP_TRANSFORM, any_col(), val_mix(), val_mix(), val_mix(), val_mix());
			end else if (kind < 75) begin
				repeat ($urandom_range(1, 4))
					queue_cmd(OP_READ, any_col(), $urandom, $urandom, $urandom, $urandom);
			end else if (kind < 88) begin
				repeat ($urandom_range(1, 6))
					queue_cmd(OP_TRANSFORM, any_col(), $urandom, $urandom, $urandom, $urandom);
			end else if (kind < 98) begin
				repeat ($urandom_range(1, 5))
					queue_cmd(3'($urandom_range(0, 7)), any_col(), $urandom, $urandom, $urandom,
						$urandom);
			end else begin
				queue_hold();
			end
		end
	endtask

	// command side: feed words from the backlog, with bursts of idle
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd <= '0;
			send_gap = 0;
			reset_matrix();
		end else begin
			if (cmd_valid && cmd_ready) begin
				apply_command(cmd);
				op_seen[cmd.op]++;
				n_accepted++;
			end
			if (!cmd_valid || cmd_ready) begin
				if (send_gap > 0) begin
					send_gap--;
					cmd_valid <= 1'b0;
				end else if (cmd_backlog.size() == 0) begin
					cmd_valid <= 1'b0;
				end else if (cmd_backlog[0].hold) begin
					if (expected_cols.size() == 0)
						backlog_head = cmd_backlog.pop_front();
					cmd_valid <= 1'b0;
				end else if (idle_on() && $urandom_range(0, 11) == 0) begin
					send_gap = $urandom_range(1, 17) - 1;
					cmd_valid <= 1'b0;
				end else begin
					backlog_head = cmd_backlog.pop_front();
					cmd <= backlog_head.w;
					cmd_valid <= 1'b1;
				end
			end
		end
	end

	// result side: check each word against the oldest expectation, stall in bursts
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			recv_gap = 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_cols.size() == 0) begin
					$display("%0t: result word with nothing expected: expected none, actual %h",
						$time, rsp);
					n_errors++;
				end else begin
					want_word = expected_cols.pop_front();
					check_word(want_word, rsp);
					if (want_word.saturated)
						n_sat_words++;
					n_checked++;
				end
			end
			if (recv_gap > 0) begin
				recv_gap--;
				rsp_ready <= 1'b0;
			end else if (idle_on() && $urandom_range(0, 9) == 0) begin
				recv_gap = $urandom_range(1, 17) - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= 1'b1;
			end
		end
	end

	initial begin
		build_directed();
		build_random();
		n_total = n_queued;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		while (cmd_backlog.size() != 0 || cmd_valid)
			@(posedge clk);
		while (expected_cols.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		$display("run: %0d words sent (%0d load, %0d transform, %0d translate, %0d scale,",
			n_accepted, op_seen[OP_LOAD], op_seen[OP_TRANSFORM], op_seen[OP_TRANSLATE],
			op_seen[OP_SCALE]);
		$display("     %0d set, %0d read, %0d unused op); %0d results checked, %0d saturated",
			op_seen[OP_SET_TRANS], op_seen[OP_READ], op_seen[OP_SPARE_A] + op_seen[OP_SPARE_B],
			n_checked, n_sat_words);
		if (n_errors == 0) begin
			$display("matrix4_transform_engine_unit verification clean");
		end else begin
			$display("matrix4_transform_engine_unit verification failed");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("timeout: stimulus or results stuck");
		$display("matrix4_transform_engine_unit verification failed");
		$finish;
	end

endmodule
